// ===== src/mbpc_pkg.sv =====
// Shared types and constants for the multi-slot button press classifier.
// Used by multi_button_press_classifier; no other dependencies.
package mbpc_pkg;

  // Slot storage and register layout.
  localparam int SLOTS_DEF   = 4;
  localparam int REG_SLOTS   = 4;
  localparam int PIN_W       = 16;
  localparam int CNT_W       = 8;
  localparam int SEL_W       = 4;
  localparam int SLOT_OUT_W  = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 3;
  localparam int ACTIVE_W    = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX       = 8'hFF;
  localparam logic [CNT_W-1:0] SHORT_TICKS_RST = 8'd20;
  localparam logic [CNT_W-1:0] LONG_TICKS_RST  = 8'd200;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PIN_MASKS   = 3'd0,
    CFG_EVENT_SELS  = 3'd1,
    CFG_ACTIVE_CNT  = 3'd2,
    CFG_SHORT_TICKS = 3'd3,
    CFG_LONG_TICKS  = 3'd4
  } cfg_idx_e;

  // Event kinds as carried on the output.
  typedef enum logic [1:0] {
    KIND_SHORT_DOWN  = 2'd0,
    KIND_LONG_DOWN   = 2'd1,
    KIND_SHORT_PRESS = 2'd2,
    KIND_LONG_PRESS  = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // One event as held in the pending and output registers.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic [PIN_W-1:0]      held;
    kind_e                 kind;
    logic                  sel;
  } event_t;

endpackage

// ===== src/multi_button_press_classifier.sv =====
// Multi-slot button press classifier: one slot evaluator shared over a scan.
// Depends on mbpc_pkg for types, register indexes and constants.
//
// Sequence: the idle state takes an item; the scan state evaluates the scanned
// slots one after another, closes the scan and passes to the flush state, which
// sends the last pending event of the item with tlast (scanned slots =
// active_slot_count, capped at SLOTS and at four). A new item is taken only in idle,
// after the last is through; output stalls hold scan and flush. Reset (rst_ni low,
// asynchronous) clears counters, held-pin records, config and control registers.
module multi_button_press_classifier #(
  parameter int SLOTS = mbpc_pkg::SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [mbpc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [mbpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream: tdata = pin_levels[15:0].
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,
  // Output stream: tdata = slot_index[1:0], held_pins[17:2], zero pad [23:18].
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,
  // tuser = event_kind[1:0], selected[2].
  output logic [2:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int PIN_W = mbpc_pkg::PIN_W;
  localparam int CNT_W = mbpc_pkg::CNT_W;
  localparam int NSCAN = (SLOTS < mbpc_pkg::REG_SLOTS) ? SLOTS : mbpc_pkg::REG_SLOTS;
  localparam int AW    = (NSCAN > 1) ? $clog2(NSCAN) : 1;
  localparam int IW    = $clog2(NSCAN + 1);

  // Configuration registers.
  logic [mbpc_pkg::CFG_DATA_W-1:0]     pin_masks_q;
  logic [mbpc_pkg::REG_SLOTS*mbpc_pkg::SEL_W-1:0] event_sels_q;
  logic [mbpc_pkg::ACTIVE_W-1:0]       active_q;
  logic [CNT_W-1:0]                    short_q;
  logic [CNT_W-1:0]                    long_q;

  // Slot state.
  logic [CNT_W-1:0] count_q  [NSCAN];
  logic [PIN_W-1:0] record_q [NSCAN];

  // Sequencer and item registers.
  mbpc_pkg::state_e state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    scan_q, scan_d;
  logic [PIN_W-1:0] pins_q;

  mbpc_pkg::event_t pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  mbpc_pkg::event_t out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;

  // Shared slot evaluator signals.
  logic [AW-1:0]    slot_a;
  logic [PIN_W-1:0] mask;
  logic [mbpc_pkg::SEL_W-1:0] sels;
  logic [PIN_W-1:0] hit;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_new;
  logic [PIN_W-1:0] rec_new;
  logic             ev_valid;
  mbpc_pkg::kind_e  ev_kind;
  logic             out_free;
  logic             in_scan;
  logic             stall;
  logic             proc;

  assign s_axis_tready = (state_q == mbpc_pkg::ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_masks_q  <= '0;
      event_sels_q <= '0;
      active_q     <= '0;
      short_q      <= mbpc_pkg::SHORT_TICKS_RST;
      long_q       <= mbpc_pkg::LONG_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mbpc_pkg::CFG_PIN_MASKS:   pin_masks_q  <= cfg_data_i;
        mbpc_pkg::CFG_EVENT_SELS:  event_sels_q <= cfg_data_i[mbpc_pkg::REG_SLOTS*mbpc_pkg::SEL_W-1:0];
        mbpc_pkg::CFG_ACTIVE_CNT:  active_q     <= cfg_data_i[mbpc_pkg::ACTIVE_W-1:0];
        mbpc_pkg::CFG_SHORT_TICKS: short_q      <= cfg_data_i[CNT_W-1:0];
        mbpc_pkg::CFG_LONG_TICKS:  long_q       <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Evaluate the slot under the scan index.
  always_comb begin
    slot_a  = idx_q[AW-1:0];
    mask    = pin_masks_q[slot_a * PIN_W +: PIN_W];
    sels    = event_sels_q[slot_a * mbpc_pkg::SEL_W +: mbpc_pkg::SEL_W];
    hit     = pins_q & mask;
    cnt     = count_q[slot_a];
    rec_new = record_q[slot_a];
    cnt_inc = cnt + CNT_W'(1);
    cnt_new = cnt;
    ev_valid = 1'b0;
    ev_kind  = mbpc_pkg::KIND_SHORT_DOWN;
    if (hit != '0) begin
      if (cnt != mbpc_pkg::COUNT_MAX) begin
        rec_new = hit;
        cnt_new = cnt_inc;
        if (cnt_inc == short_q) begin
          ev_valid = 1'b1;
          ev_kind  = mbpc_pkg::KIND_SHORT_DOWN;
        end else if (cnt_inc == long_q) begin
          ev_valid = 1'b1;
          ev_kind  = mbpc_pkg::KIND_LONG_DOWN;
        end
      end
    end else begin
      // Release: a long press wins over a short press.
      cnt_new = '0;
      if (cnt >= long_q) begin
        ev_valid = 1'b1;
        ev_kind  = mbpc_pkg::KIND_LONG_PRESS;
      end else if (cnt >= short_q) begin
        ev_valid = 1'b1;
        ev_kind  = mbpc_pkg::KIND_SHORT_PRESS;
      end
    end
  end

  // A new event pushes the pending one out, so it waits for a free output.
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_scan  = (state_q == mbpc_pkg::ST_SCAN) && (idx_q != scan_q);
  assign stall    = ev_valid && pend_valid_q && !out_free;
  assign proc     = in_scan && !stall;

  // Next state, pending event and output register.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    unique case (state_q)
      mbpc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          idx_d   = '0;
          scan_d  = (active_q > mbpc_pkg::ACTIVE_W'(NSCAN)) ? IW'(NSCAN) : IW'(active_q);
          state_d = mbpc_pkg::ST_SCAN;
        end
      end
      mbpc_pkg::ST_SCAN: begin
        if (idx_q == scan_q) begin
          state_d = mbpc_pkg::ST_FLUSH;
        end else if (proc) begin
          idx_d = idx_q + IW'(1);
          if (ev_valid) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_last_d  = 1'b0;
              out_valid_d = 1'b1;
            end
            pend_d.slot  = mbpc_pkg::SLOT_OUT_W'(slot_a);
            pend_d.held  = rec_new;
            pend_d.kind  = ev_kind;
            pend_d.sel   = sels[ev_kind];
            pend_valid_d = 1'b1;
          end
        end
      end
      mbpc_pkg::ST_FLUSH: begin
        // The last event of the item leaves with tlast set.
        if (!pend_valid_q) begin
          state_d = mbpc_pkg::ST_IDLE;
        end else if (out_free) begin
          out_d        = pend_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = mbpc_pkg::ST_IDLE;
        end
      end
      default: state_d = mbpc_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mbpc_pkg::ST_IDLE;
      idx_q        <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      scan_q       <= scan_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (s_axis_tvalid && s_axis_tready) begin
      pins_q <= s_axis_tdata;
    end
  end

  // Slot counters and held-pin records.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSCAN; k++) begin
        count_q[k]  <= '0;
        record_q[k] <= '0;
      end
    end else if (proc) begin
      count_q[slot_a]  <= cnt_new;
      record_q[slot_a] <= rec_new;
    end
  end

  // Output ports.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.held, out_q.slot};
  assign m_axis_tuser  = {out_q.sel, out_q.kind};
  assign m_axis_tlast  = out_last_q;

  // Nothing is left pending once the block is ready for the next item.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbpc_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("pending event left over while idle");

  // The scan index never runs past the scanned slot count.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbpc_pkg::ST_SCAN) |-> (idx_q <= scan_q))
    else $error("scan index beyond scan count");

  // A flush with nothing pending returns straight to idle.
  a_flush_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbpc_pkg::ST_FLUSH && !pend_valid_q) |=> (state_q == mbpc_pkg::ST_IDLE))
    else $error("flush did not return to idle");

endmodule
